FILE: rtl/core/lecp_pkg.sv
package lecp_pkg;

    localparam int LINE_DEPTH  = 32;
    localparam int LED_COUNT   = 6;
    localparam int IDX_W       = $clog2(LINE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int LED_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LED_W-1:0]  led;
    } echo_item_t;

    typedef struct packed {
        logic       valid;
        echo_item_t item;
    } queue_push_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ECHO,
        ST_CR,
        ST_LF
    } front_state_t;

endpackage

FILE: rtl/core/lecp_front.sv
module lecp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output lecp_pkg::queue_push_t push,
    input  logic                  queue_full
);
    import lecp_pkg::*;

    front_state_t      state_reg;
    front_state_t      state_next;
    logic [BYTE_W-1:0] line_reg [LINE_DEPTH];
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic [LED_W-1:0]  led_reg;

    logic              accept;
    logic              is_cr;
    logic [BYTE_W-1:0] slot0;
    logic [BYTE_W-1:0] slot1;
    logic [BYTE_W-1:0] slot2;
    logic [BYTE_W-1:0] digit;
    logic              cmd_on;
    logic              cmd_off;
    logic              cmd_ok;
    logic [LED_W-1:0]  led_cmd;
    logic [BYTE_W-1:0] cur_byte;

    assign accept   = in_valid && !in_stall;
    assign is_cr    = (rx_byte == CHAR_CR);
    assign cur_byte = line_reg[ptr_reg];

    // command slots, with the cr byte still in its slot
    assign slot0 = (idx_reg == IDX_W'(0)) ? rx_byte : line_reg[0];
    assign slot1 = (idx_reg == IDX_W'(1)) ? rx_byte : line_reg[1];
    assign slot2 = (idx_reg == IDX_W'(2)) ? rx_byte : line_reg[2];

    always_comb
    begin
        digit   = slot2 - DIGIT_BASE;
        cmd_on  = (slot1 == CHAR_PLUS);
        cmd_off = (slot1 inside {CHAR_MINUS, CHAR_QUERY});
        cmd_ok  = (slot0 == CHAR_A) && (cmd_on || cmd_off) && (digit < BYTE_W'(LED_COUNT));
        led_cmd = led_reg;
        for (int i = 0; i < LED_W; i++)
        begin
            if (cmd_ok && (digit == BYTE_W'(i)))
            begin
                led_cmd[i] = cmd_on;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && is_cr)
                begin
                    state_next = ST_ECHO;
                end
            end
            ST_ECHO:
            begin
                if (cur_byte == CHAR_NUL)
                begin
                    state_next = ST_CR;
                end
            end
            ST_CR:
            begin
                if (!queue_full)
                begin
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                if (!queue_full)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall        = 1'b1;
        push.valid      = 1'b0;
        push.item.data  = cur_byte;
        push.item.last  = 1'b0;
        push.item.led   = led_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                in_stall = 1'b0;
            end
            ST_ECHO:
            begin
                push.valid = (cur_byte != CHAR_NUL) && !queue_full;
            end
            ST_CR:
            begin
                push.valid     = !queue_full;
                push.item.data = CHAR_CR;
            end
            ST_LF:
            begin
                push.valid     = !queue_full;
                push.item.data = CHAR_LF;
                push.item.last = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            idx_reg   <= '0;
            ptr_reg   <= '0;
            led_reg   <= '0;
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (is_cr)
                begin
                    // cr slot reads back as zero, ending the echo there
                    line_reg[idx_reg] <= CHAR_NUL;
                    led_reg           <= led_cmd;
                    ptr_reg           <= '0;
                end
                else
                begin
                    line_reg[idx_reg] <= rx_byte;
                    idx_reg <= (idx_reg == IDX_W'(LINE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
                end
            end
            if ((state_reg == ST_ECHO) && push.valid)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if ((state_reg == ST_LF) && !queue_full)
            begin
                for (int i = 0; i < LINE_DEPTH; i++)
                begin
                    if (i <= int'(idx_reg))
                    begin
                        line_reg[i] <= '0;
                    end
                end
                idx_reg <= '0;
            end
        end
    end

endmodule

FILE: rtl/core/lecp_queue.sv
module lecp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lecp_pkg::queue_push_t push,
    output logic                  full,
    input  logic                  pop,
    output lecp_pkg::echo_item_t  head,
    output logic                  empty
);
    import lecp_pkg::*;

    echo_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/lecp_back.sv
module lecp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lecp_pkg::echo_item_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           echo_byte,
    output logic                 echo_last,
    output logic [5:0]           led_bits
);
    import lecp_pkg::*;

    logic       valid_reg;
    echo_item_t item_reg;

    assign pop       = !empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign echo_byte = item_reg.data;
    assign echo_last = item_reg.last;
    assign led_bits  = item_reg.led;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/line_echo_led_command_parser.sv
// Serial line collector with LED command decode and line echo. Each received byte is stored in
// a 32-slot line store; a byte other than CR is accepted when offered. A CR runs the command in
// slots 0 to 2 ("A+n" switches LED n on, "A-n" or "A?n" switches it off, n an ASCII digit
// below 6), then echoes the stored line up to its first zero byte followed by CR and LF, with
// echo_last marking the LF and led_bits carrying the LED state after the command on every
// echoed item. While a line is echoed the input is stalled: the front sequencer walks the line
// store one slot per cycle while the queue is not full, then pushes CR and LF. Echo items pass
// through a 4-entry queue and an output register, so a stalled output only backs up the
// sequencer once the queue is full. The line store is held in flip-flops and cleared by reset
// directly, so the block is ready as soon as reset is released.
module line_echo_led_command_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] echo_byte,
    output logic       echo_last,
    output logic [5:0] led_bits
);
    import lecp_pkg::*;

    queue_push_t push;
    echo_item_t  head;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;

    // front: line store, command decode and echo sequencer
    lecp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .push       (push),
        .queue_full (queue_full)
    );

    // queue decouples the sequencer from output backpressure
    lecp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .head  (head),
        .empty (queue_empty)
    );

    // back: registered output stage
    lecp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .echo_byte (echo_byte),
        .echo_last (echo_last),
        .led_bits  (led_bits)
    );

endmodule
